// ===== rtl/nfsa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nfsa_pkg
// shared types and constants of the next-fit slot allocator
// ----------------------------------------------------------------------------
package nfsa_pkg;

  localparam int SLOT_COUNT_DEF = 64;
  localparam int SLOT_W         = 6;

  typedef enum logic {
    OP_ALLOCATE = 1'b0,
    OP_RELEASE  = 1'b1
  } op_e;

  typedef enum logic {
    ST_DONE = 1'b0,
    ST_FULL = 1'b1
  } status_e;

endpackage
`default_nettype wire

// ===== rtl/nfsa_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nfsa_req_if
// request channel: operation and slot index with valid/ready
// ----------------------------------------------------------------------------
interface nfsa_req_if import nfsa_pkg::*; ();

  logic              valid;
  logic              ready;
  op_e               operation;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, output operation, output slot, input ready);
  modport sink   (input valid, input operation, input slot, output ready);

endinterface
`default_nettype wire

// ===== rtl/nfsa_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nfsa_rsp_if
// response channel: granted slot and status with valid/ready
// ----------------------------------------------------------------------------
interface nfsa_rsp_if import nfsa_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] granted_slot;
  status_e           status;

  modport source (output valid, output granted_slot, output status, input ready);
  modport sink   (input valid, input granted_slot, input status, output ready);

endinterface
`default_nettype wire

// ===== rtl/nfsa_pick.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nfsa_pick
// rotated priority encoder: first free slot at or after the pointer, with wrap
// ----------------------------------------------------------------------------
module nfsa_pick import nfsa_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  localparam int IDX_W     = $clog2(SLOT_COUNT)
) (
  input  logic [SLOT_COUNT-1:0] busy_i,
  input  logic [IDX_W-1:0]      ptr_i,
  output logic                  found_o,
  output logic [IDX_W-1:0]      idx_o
);

  logic [SLOT_COUNT-1:0] free;
  logic [SLOT_COUNT-1:0] free_hi;
  logic                  found_hi;
  logic [IDX_W-1:0]      idx_hi;
  logic [IDX_W-1:0]      idx_any;

  always_comb begin
    free = ~busy_i;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      free_hi[i] = free[i] && (IDX_W'(i) >= ptr_i);
    end
    found_hi = 1'b0;
    idx_hi   = '0;
    idx_any  = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (free_hi[i]) begin
        found_hi = 1'b1;
        idx_hi   = IDX_W'(i);
      end
      if (free[i]) begin
        idx_any = IDX_W'(i);
      end
    end
    found_o = |free;
    idx_o   = found_hi ? idx_hi : idx_any;
  end

endmodule
`default_nettype wire

// ===== rtl/next_fit_slot_allocator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// next_fit_slot_allocator_unit
// next-fit slot allocator over a busy map of SLOT_COUNT slots
//
// requests arrive on req_i (valid/ready). an allocate request takes the first
// free slot at or after the next-fit pointer, wrapping once, marks it busy and
// moves the pointer just past it; if no slot is free the response carries
// status full and slot zero. a release request clears the named slot; an
// index at or beyond SLOT_COUNT is ignored. every request gives exactly one
// response on rsp_o (valid/ready), in order.
// a request passes through an input register and then the response register.
// throughput: one request per cycle while the receiver takes each response;
// the rotated priority encode over the busy map sits between the input
// register and the response register.
// reset clears the busy map (all slots free), zeroes the pointer and drops
// both valid flags. when the receiver stalls, the response register holds
// and the input register keeps its request, so req_i.ready falls only when
// both stages are full.
// ----------------------------------------------------------------------------
module next_fit_slot_allocator_unit import nfsa_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  nfsa_req_if.sink      req_i,
  nfsa_rsp_if.source    rsp_o
);

  localparam int IDX_W = $clog2(SLOT_COUNT);

  logic                  s1_valid_q, s1_valid_d;
  op_e                   s1_op_q;
  logic [SLOT_W-1:0]     s1_slot_q;

  logic [SLOT_COUNT-1:0] busy_q, busy_d;
  logic [IDX_W-1:0]      ptr_q, ptr_d;

  logic                  out_valid_q, out_valid_d;
  logic [SLOT_W-1:0]     out_granted_q, out_granted_d;
  status_e               out_status_q, out_status_d;

  logic                  advance;
  logic                  commit;
  logic                  accept;
  logic                  pick_found;
  logic [IDX_W-1:0]      pick_idx;
  logic [SLOT_COUNT-1:0] clr_mask;

  nfsa_pick #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_pick (
    .busy_i  (busy_q),
    .ptr_i   (ptr_q),
    .found_o (pick_found),
    .idx_o   (pick_idx)
  );

  assign advance     = !out_valid_q || rsp_o.ready;
  assign commit      = s1_valid_q && advance;
  assign req_i.ready = !s1_valid_q || advance;
  assign accept      = req_i.valid && req_i.ready;

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.granted_slot = out_granted_q;
  assign rsp_o.status       = out_status_q;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      clr_mask[i] = (32'(s1_slot_q) == i);
    end
  end

  always_comb begin
    s1_valid_d    = req_i.ready ? req_i.valid : s1_valid_q;
    out_valid_d   = advance ? s1_valid_q : out_valid_q;
    busy_d        = busy_q;
    ptr_d         = ptr_q;
    out_granted_d = '0;
    out_status_d  = ST_DONE;
    if (commit) begin
      if (s1_op_q == OP_ALLOCATE) begin
        if (pick_found) begin
          busy_d[pick_idx] = 1'b1;
          ptr_d            = (pick_idx == IDX_W'(SLOT_COUNT - 1)) ? '0 : pick_idx + 1'b1;
          out_granted_d    = SLOT_W'(pick_idx);
        end else begin
          out_status_d = ST_FULL;
        end
      end else begin
        busy_d = busy_q & ~clr_mask;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      busy_q      <= '0;
      ptr_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      busy_q      <= busy_d;
      ptr_q       <= ptr_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q   <= req_i.operation;
      s1_slot_q <= req_i.slot;
    end
    if (commit) begin
      out_granted_q <= out_granted_d;
      out_status_q  <= out_status_d;
    end
  end

endmodule
`default_nettype wire

// ===== verif/next_fit_slot_allocator_unit_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// next_fit_slot_allocator_unit_test
// self-checking bench for the next-fit slot allocator
//
// drives allocate and release requests through the request channel and
// predicts each response from a local copy of the busy map and the next-fit
// pointer. a short directed sequence covers next-fit skipping and releases
// of free slots. random segments then swing the pool between nearly empty
// and full, which exercises pool-full responses and pointer wrap. both
// channels idle and stall in random bursts, except during the final stretch.
// ----------------------------------------------------------------------------
module next_fit_slot_allocator_unit_test;
  import nfsa_pkg::*;

  localparam int SLOTS         = SLOT_COUNT_DEF;
  localparam int RANDOM_ITEMS  = 850;
  localparam int QUIET_FROM    = 750;
  localparam int STALL_LIMIT   = 500;

  typedef struct packed {
    logic [SLOT_W-1:0] granted;
    status_e           status;
  } slot_grant_t;

  class slot_pool_ledger;
    bit [SLOTS-1:0] busy;
    int             next_ptr;
    slot_grant_t    expected_grants[$];
    int             errors;

    function new();
      busy     = '0;
      next_ptr = 0;
      errors   = 0;
    endfunction

    function void note_request(op_e op, logic [SLOT_W-1:0] slot);
      slot_grant_t grant;
      int          idx;
      bit          found;
      grant.granted = '0;
      grant.status  = ST_DONE;
      found         = 1'b0;
      if (op == OP_ALLOCATE) begin
        for (int k = 0; k < SLOTS && !found; k++) begin
          idx = (next_ptr + k) % SLOTS;
          if (!busy[idx]) begin
            busy[idx]     = 1'b1;
            next_ptr      = (idx + 1) % SLOTS;
            grant.granted = idx[SLOT_W-1:0];
            found         = 1'b1;
          end
        end
        if (!found) grant.status = ST_FULL;
      end else if (int'(slot) < SLOTS) begin
        busy[slot] = 1'b0;
      end
      expected_grants.push_back(grant);
    endfunction

    function void check_grant(logic [SLOT_W-1:0] granted, status_e status);
      slot_grant_t want;
      if (expected_grants.size() == 0) begin
        $display("%0t unexpected response: expected none, actual slot %0d status %s",
                 $time, granted, status.name());
        errors++;
      end else begin
        want = expected_grants.pop_front();
        if (granted !== want.granted) begin
          $display("%0t granted_slot mismatch: expected %0d, actual %0d",
                   $time, want.granted, granted);
          errors++;
        end
        if (status !== want.status) begin
          $display("%0t status mismatch: expected %s, actual %s",
                   $time, want.status.name(), status.name());
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_grants.size();
    endfunction

    // a busy slot if there is one, found from a random start
    function logic [SLOT_W-1:0] pick_busy_slot();
      int start;
      int idx;
      start = $urandom_range(0, SLOTS - 1);
      for (int k = 0; k < SLOTS; k++) begin
        idx = (start + k) % SLOTS;
        if (busy[idx]) return idx[SLOT_W-1:0];
      end
      return start[SLOT_W-1:0];
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   quiet;
  bit   rsp_stalls_on;
  int   idle_cycles;

  slot_pool_ledger ledger = new();

  nfsa_req_if req_if ();
  nfsa_rsp_if rsp_if ();

  next_fit_slot_allocator_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // responses are checked before the request of the same edge is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) ledger.check_grant(rsp_if.granted_slot, rsp_if.status);
      if (req_if.valid && req_if.ready) ledger.note_request(req_if.operation, req_if.slot);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("next_fit_slot_allocator_unit_test: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stalls in bursts
  initial begin
    int stall_left;
    stall_left   = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready = 1'b0;
      end else if (!quiet && rsp_stalls_on && $urandom_range(0, 6) == 0) begin
        stall_left   = $urandom_range(1, 14) - 1;
        rsp_if.ready = 1'b0;
      end else begin
        rsp_if.ready = rst_ni;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(op_e op, logic [SLOT_W-1:0] slot);
    req_if.valid     = 1'b1;
    req_if.operation = op;
    req_if.slot      = slot;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  task automatic pause_requests(int cycles);
    req_if.valid = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  initial begin
    int sent;
    int seg_len;
    int alloc_pct;
    bit req_gaps;
    req_if.valid     = 1'b0;
    req_if.operation = OP_ALLOCATE;
    req_if.slot      = '0;
    rst_ni           = 1'b0;
    quiet            = 1'b0;
    rsp_stalls_on    = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: next-fit order, skipping a freed slot, releases of free slots
    send_request(OP_ALLOCATE, '0);
    send_request(OP_ALLOCATE, '1);
    send_request(OP_ALLOCATE, 6'd17);
    send_request(OP_RELEASE, 6'd1);
    send_request(OP_ALLOCATE, '0);
    send_request(OP_RELEASE, 6'd63);
    send_request(OP_RELEASE, 6'd1);
    send_request(OP_RELEASE, 6'd0);
    send_request(OP_ALLOCATE, 6'd42);
    send_request(OP_RELEASE, 6'd2);
    send_request(OP_RELEASE, 6'd3);
    send_request(OP_RELEASE, 6'd4);
    send_request(OP_ALLOCATE, '0);
    send_request(OP_RELEASE, 6'd5);

    // random segments swing the pool between empty and full
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      seg_len       = $urandom_range(40, 120);
      req_gaps      = 1'($urandom_range(0, 1));
      rsp_stalls_on = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 2))
        0:       alloc_pct = 92;
        1:       alloc_pct = 55;
        default: alloc_pct = 20;
      endcase
      for (int i = 0; i < seg_len && sent < RANDOM_ITEMS; i++) begin
        if (sent >= QUIET_FROM) quiet = 1'b1;
        if (!quiet && req_gaps && $urandom_range(0, 5) == 0)
          pause_requests($urandom_range(1, 14));
        if ($urandom_range(0, 99) < alloc_pct)
          send_request(OP_ALLOCATE, SLOT_W'($urandom));
        else if ($urandom_range(0, 3) != 0)
          send_request(OP_RELEASE, ledger.pick_busy_slot());
        else
          send_request(OP_RELEASE, SLOT_W'($urandom));
        sent++;
      end
    end
    req_if.valid = 1'b0;

    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("next_fit_slot_allocator_unit_test: PASS");
    end else begin
      $display("next_fit_slot_allocator_unit_test: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
